/* sv/lcdw_pkg.sv */
`default_nettype none
package lcdw_pkg;

  // Request actions.
  typedef enum logic [1:0] {
    ACT_CMD    = 2'd0,
    ACT_DATA   = 2'd1,
    ACT_CURSOR = 2'd2,
    ACT_INIT   = 2'd3
  } lcdw_action_t;

  // Configuration register indexes (byte address / 4).
  typedef enum logic [1:0] {
    REG_FUNCTION_SET = 2'd0,
    REG_ENTRY_MODE   = 2'd1,
    REG_DISPLAY_ON   = 2'd2,
    REG_UNUSED       = 2'd3
  } lcdw_reg_t;

  localparam int unsigned CFG_ADDR_W = 4;
  localparam int unsigned WAIT_W     = 15;

  localparam logic [WAIT_W-1:0] LONG_WAIT_US  = WAIT_W'(3000);
  localparam logic [WAIT_W-1:0] SHORT_WAIT_US = WAIT_W'(50);
  localparam logic [WAIT_W-1:0] POWER_WAIT_US = WAIT_W'(20000);
  localparam logic [WAIT_W-1:0] WAKE1_WAIT_US = WAIT_W'(5000);
  localparam logic [WAIT_W-1:0] WAKE_WAIT_US  = WAIT_W'(150);

  localparam logic [7:0] CMD_CLEAR       = 8'h01;
  localparam logic [7:0] CMD_HOME        = 8'h02;
  localparam logic [7:0] CMD_DISPLAY_OFF = 8'h08;
  localparam logic [7:0] CMD_SET_DDRAM   = 8'h80;

  localparam logic [7:0] FUNCTION_SET_RST = 8'h28;
  localparam logic [7:0] ENTRY_MODE_RST   = 8'h06;
  localparam logic [7:0] DISPLAY_ON_RST   = 8'h0C;

  typedef struct packed {
    logic [1:0] action;
    logic [7:0] byte_value;
    logic       row;
    logic [5:0] column;
  } in_req_t;

  typedef struct packed {
    logic              register_select;
    logic [3:0]        nibble;
    logic              strobe_res;
    logic [WAIT_W-1:0] wait_after_us;
    logic              last;
  } out_res_t;

  // Byte source of one transfer.
  typedef enum logic [2:0] {
    SRC_LIT  = 3'd0,
    SRC_REQ  = 3'd1,
    SRC_FS   = 3'd2,
    SRC_DOFF = 3'd3,
    SRC_CLR  = 3'd4,
    SRC_EM   = 3'd5,
    SRC_DON  = 3'd6
  } src_sel_t;

  // Wait that follows one transfer.
  typedef enum logic [2:0] {
    W_ZERO  = 3'd0,
    W_POWER = 3'd1,
    W_WAKE1 = 3'd2,
    W_WAKE  = 3'd3,
    W_SHORT = 3'd4,
    W_LONG  = 3'd5,
    W_BYTE  = 3'd6
  } wait_sel_t;

  // One microcode word. fin marks the last transfer of a request.
  typedef struct packed {
    src_sel_t   src;
    logic       hi;
    logic [3:0] lit;
    logic       strobe;
    wait_sel_t  wsel;
    logic       fin;
  } ucode_t;

  localparam int unsigned UC_DEPTH = 17;
  localparam int unsigned PC_W     = $clog2(UC_DEPTH);

  localparam logic [PC_W-1:0] UC_BYTE = PC_W'(0);
  localparam logic [PC_W-1:0] UC_INIT = PC_W'(2);

  function automatic ucode_t uc_word(input src_sel_t s, input logic h, input logic [3:0] l,
                                     input logic st, input wait_sel_t w, input logic f);
    ucode_t u;
    u.src    = s;
    u.hi     = h;
    u.lit    = l;
    u.strobe = st;
    u.wsel   = w;
    u.fin    = f;
    return u;
  endfunction

  // Program: one byte transfer at UC_BYTE, the power-up sequence at UC_INIT.
  function automatic ucode_t lcdw_ucode(input logic [PC_W-1:0] pc);
    ucode_t u;
    case (pc)
      5'd0:    u = uc_word(SRC_REQ,  1'b1, 4'h0, 1'b1, W_ZERO,  1'b0);
      5'd1:    u = uc_word(SRC_REQ,  1'b0, 4'h0, 1'b1, W_BYTE,  1'b1);
      5'd2:    u = uc_word(SRC_LIT,  1'b0, 4'h0, 1'b0, W_POWER, 1'b0);
      5'd3:    u = uc_word(SRC_LIT,  1'b0, 4'h3, 1'b1, W_WAKE1, 1'b0);
      5'd4:    u = uc_word(SRC_LIT,  1'b0, 4'h3, 1'b1, W_WAKE,  1'b0);
      5'd5:    u = uc_word(SRC_LIT,  1'b0, 4'h3, 1'b1, W_WAKE,  1'b0);
      5'd6:    u = uc_word(SRC_LIT,  1'b0, 4'h2, 1'b1, W_WAKE,  1'b0);
      5'd7:    u = uc_word(SRC_FS,   1'b1, 4'h0, 1'b1, W_ZERO,  1'b0);
      5'd8:    u = uc_word(SRC_FS,   1'b0, 4'h0, 1'b1, W_SHORT, 1'b0);
      5'd9:    u = uc_word(SRC_DOFF, 1'b1, 4'h0, 1'b1, W_ZERO,  1'b0);
      5'd10:   u = uc_word(SRC_DOFF, 1'b0, 4'h0, 1'b1, W_SHORT, 1'b0);
      5'd11:   u = uc_word(SRC_CLR,  1'b1, 4'h0, 1'b1, W_ZERO,  1'b0);
      5'd12:   u = uc_word(SRC_CLR,  1'b0, 4'h0, 1'b1, W_LONG,  1'b0);
      5'd13:   u = uc_word(SRC_EM,   1'b1, 4'h0, 1'b1, W_ZERO,  1'b0);
      5'd14:   u = uc_word(SRC_EM,   1'b0, 4'h0, 1'b1, W_SHORT, 1'b0);
      5'd15:   u = uc_word(SRC_DON,  1'b1, 4'h0, 1'b1, W_ZERO,  1'b0);
      5'd16:   u = uc_word(SRC_DON,  1'b0, 4'h0, 1'b1, W_SHORT, 1'b1);
      default: u = uc_word(SRC_LIT,  1'b0, 4'h0, 1'b0, W_ZERO,  1'b1);
    endcase
    return u;
  endfunction

endpackage
`default_nettype wire

/* sv/lcdw_seq.sv */
`default_nettype none
module lcdw_seq
  import lcdw_pkg::*;
(
  input  wire logic   clk,
  input  wire logic   rst_n,
  input  wire logic   start,
  input  wire logic   start_init,
  input  wire logic   advance,
  output logic        busy,
  output ucode_t      uc
);

  logic            busy_r, busy_nxt;
  logic [PC_W-1:0] pc_r, pc_nxt;

  assign uc   = lcdw_ucode(pc_r);
  assign busy = busy_r;

  // The program counter steps once per emitted transfer; the word marked
  // fin ends the request and frees the input side.
  always_comb begin
    busy_nxt = busy_r;
    pc_nxt   = pc_r;
    if (start) begin
      busy_nxt = 1'b1;
      pc_nxt   = start_init ? UC_INIT : UC_BYTE;
    end else if (advance) begin
      if (uc.fin) begin
        busy_nxt = 1'b0;
      end else begin
        pc_nxt = pc_r + PC_W'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      pc_r   <= UC_BYTE;
    end else begin
      busy_r <= busy_nxt;
      pc_r   <= pc_nxt;
    end
  end

endmodule
`default_nettype wire

/* sv/char_lcd_4bit_write_sequencer_unit.sv */
`default_nettype none
// Channel   Direction  Signals                                   Payload
// request   in         in_valid, in_ready, in_data               in_req_t
// result    out        out_valid, out_ready, out_data            out_res_t
// config    in/out     psel, penable, pwrite, paddr, pwdata,     three 8-bit words
//                      prdata, pready
//
// A request is taken when the unit is idle, then one result per cycle follows
// while the output is not stalled: two results for a command, data or cursor
// request and fifteen for init. The pace is set by the microcode program
// counter, which steps once per transfer. Reset is synchronous and active low
// and restores the register defaults. A stalled output holds the program
// counter in place.
module char_lcd_4bit_write_sequencer_unit
  import lcdw_pkg::*;
(
  input  wire logic                  clk,
  input  wire logic                  rst_n,
  input  wire logic                  in_valid,
  output logic                       in_ready,
  input  wire in_req_t               in_data,
  output logic                       out_valid,
  input  wire logic                  out_ready,
  output out_res_t                   out_data,
  input  wire logic                  psel,
  input  wire logic                  penable,
  input  wire logic                  pwrite,
  input  wire logic [CFG_ADDR_W-1:0] paddr,
  input  wire logic [31:0]           pwdata,
  output logic [31:0]                prdata,
  output logic                       pready
);

  // Configuration registers, written by the access phase of an APB write.
  logic [7:0] fs_word_r, em_word_r, don_word_r;
  lcdw_reg_t  reg_idx;
  logic       cfg_wr;

  assign pready  = 1'b1;
  assign reg_idx = lcdw_reg_t'(paddr[CFG_ADDR_W-1:2]);
  assign cfg_wr  = psel & penable & pwrite & pready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fs_word_r  <= FUNCTION_SET_RST;
      em_word_r  <= ENTRY_MODE_RST;
      don_word_r <= DISPLAY_ON_RST;
    end else if (cfg_wr) begin
      case (reg_idx)
        REG_FUNCTION_SET: fs_word_r  <= pwdata[7:0];
        REG_ENTRY_MODE:   em_word_r  <= pwdata[7:0];
        REG_DISPLAY_ON:   don_word_r <= pwdata[7:0];
        default:          ;
      endcase
    end
  end

  always_comb begin
    case (reg_idx)
      REG_FUNCTION_SET: prdata = {24'd0, fs_word_r};
      REG_ENTRY_MODE:   prdata = {24'd0, em_word_r};
      REG_DISPLAY_ON:   prdata = {24'd0, don_word_r};
      default:          prdata = 32'd0;
    endcase
  end

  // Request capture. A cursor move is folded into a set-DDRAM-address
  // command here, so the byte program serves commands, data and cursor moves.
  logic       busy, in_fire, advance;
  logic [7:0] byte_r, byte_nxt, cursor_cmd;
  logic       rs_r, rs_nxt;
  ucode_t     uc;

  assign in_ready   = ~busy;
  assign in_fire    = in_valid & in_ready;
  assign cursor_cmd = (CMD_SET_DDRAM | {1'b0, in_data.row, 6'd0}) + {2'd0, in_data.column};

  always_comb begin
    byte_nxt = byte_r;
    rs_nxt   = rs_r;
    if (in_fire) begin
      byte_nxt = (lcdw_action_t'(in_data.action) == ACT_CURSOR) ? cursor_cmd
                                                               : in_data.byte_value;
      rs_nxt   = (lcdw_action_t'(in_data.action) == ACT_DATA);
    end
  end

  always_ff @(posedge clk) begin
    byte_r <= byte_nxt;
    rs_r   <= rs_nxt;
  end

  logic     out_valid_r, out_valid_nxt;
  out_res_t out_data_r, out_data_nxt;

  // A new transfer is produced whenever the output register is empty or
  // being emptied in this cycle.
  assign advance = busy & (~out_valid_r | out_ready);

  lcdw_seq u_seq (
    .clk        (clk),
    .rst_n      (rst_n),
    .start      (in_fire),
    .start_init (lcdw_action_t'(in_data.action) == ACT_INIT),
    .advance    (advance),
    .busy       (busy),
    .uc         (uc)
  );

  // Datapath driven by the current control word.
  logic [7:0]        src_byte;
  logic [WAIT_W-1:0] wait_val;
  out_res_t          res;

  always_comb begin
    case (uc.src)
      SRC_REQ:  src_byte = byte_r;
      SRC_FS:   src_byte = fs_word_r;
      SRC_DOFF: src_byte = CMD_DISPLAY_OFF;
      SRC_CLR:  src_byte = CMD_CLEAR;
      SRC_EM:   src_byte = em_word_r;
      SRC_DON:  src_byte = don_word_r;
      default:  src_byte = 8'd0;
    endcase
  end

  always_comb begin
    case (uc.wsel)
      W_POWER: wait_val = POWER_WAIT_US;
      W_WAKE1: wait_val = WAKE1_WAIT_US;
      W_WAKE:  wait_val = WAKE_WAIT_US;
      W_SHORT: wait_val = SHORT_WAIT_US;
      W_LONG:  wait_val = LONG_WAIT_US;
      W_BYTE: begin
        // Clear and return-home need the long wait; data never does.
        if (!rs_r && (byte_r == CMD_CLEAR || byte_r == CMD_HOME)) begin
          wait_val = LONG_WAIT_US;
        end else begin
          wait_val = SHORT_WAIT_US;
        end
      end
      default: wait_val = '0;
    endcase
  end

  always_comb begin
    res.register_select = (uc.src == SRC_REQ) ? rs_r : 1'b0;
    if (uc.src == SRC_LIT) begin
      res.nibble = uc.lit;
    end else begin
      res.nibble = uc.hi ? src_byte[7:4] : src_byte[3:0];
    end
    res.strobe_res    = uc.strobe;
    res.wait_after_us = wait_val;
    res.last          = uc.fin;
  end

  // Output register: separates the program from a stalled consumer.
  always_comb begin
    out_valid_nxt = out_valid_r;
    out_data_nxt  = out_data_r;
    if (advance) begin
      out_valid_nxt = 1'b1;
      out_data_nxt  = res;
    end else if (out_ready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
    out_data_r <= out_data_nxt;
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

endmodule
`default_nettype wire
